@@ design/cir_pkg.sv @@
// ----------------------------------------------------------------------------
// cir_pkg
// Shared constants, result codes and the pipeline word type of the
// collision impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

   localparam int UNIT_BITS   = 24;     // fraction bits of the unit normal and weights
   localparam int REST_BITS   = 16;     // fraction bits of the restitution factor
   localparam int REST_ONE    = 65536;
   localparam int SQRT_STEPS  = 32;     // one result bit per stage

   // stage map
   localparam int ST_SQ       = 1;
   localparam int ST_SUM      = 2;
   localparam int ST_SQRT0    = 3;
   localparam int ST_UINIT    = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_UDIV0    = ST_UINIT + 1;
   localparam int ST_USIGN    = ST_UDIV0 + UNIT_BITS;
   localparam int ST_PROD     = ST_USIGN + 1;
   localparam int ST_VN       = ST_PROD + 1;
   localparam int ST_KVN      = ST_VN + 1;
   localparam int ST_T        = ST_KVN + 1;
   localparam int ST_SP       = ST_T + 1;
   localparam int ST_S        = ST_SP + 1;
   localparam int ST_DP       = ST_S + 1;
   localparam int ST_ADD      = ST_DP + 1;
   localparam int ST_OUT      = ST_ADD + 1;

   localparam logic [1:0] OUT_APPLIED    = 2'd0;
   localparam logic [1:0] OUT_NO_CONTACT = 2'd1;
   localparam logic [1:0] OUT_SEPARATING = 2'd2;
   localparam logic [1:0] OUT_DEGENERATE = 2'd3;

   typedef struct packed {
      logic [2:0][31:0] va;
      logic [2:0][31:0] vb;
      logic [2:0][31:0] nv;
      logic [31:0]      ma;
      logic [31:0]      mb;
      logic             neg_depth;
      logic             nzero;
      logic [2:0][63:0] sq;
      logic [2:0][32:0] r;
      logic [32:0]      msum;
      logic [63:0]      rad;
      logic [33:0]      srem;
      logic [31:0]      root;
      logic [1:0][24:0] wq;
      logic [1:0][32:0] wrem;
      logic [2:0]       nneg;
      logic [2:0][24:0] uq;
      logic [2:0][31:0] urem;
      logic [2:0][25:0] u;
      logic [2:0][58:0] p;
      logic [34:0]      vn;
      logic [1:0]       outcome;
      logic [52:0]      kvn;
      logic [36:0]      t;
      logic [1:0][61:0] sp;
      logic [1:0][37:0] s;
      logic [5:0][61:0] dp;
      logic [5:0][38:0] sum;
      logic [5:0][31:0] res;
   } item_type;

endpackage

@@ design/collision_impulse_resolver.sv @@
// ----------------------------------------------------------------------------
// collision_impulse_resolver
// Impulse exchange between two bodies along a contact normal, Q16.16.
// ----------------------------------------------------------------------------
// req_ carries one contact word per beat: both velocities, inverse masses,
// normal and depth. rsp_ returns the resolved velocities in tdata and the
// outcome code in tuser. csr_wr_en/csr_wr_data load the restitution factor
// (write only while the pipeline is empty).
// An accepted word passes through all 70 pipeline stages before rsp_tvalid
// rises. Throughput: one word per cycle while rsp_ does not stall. Every
// stage does one step: a bit pair of the square root, one quotient bit of
// each divider, or one multiply or add.
// A stall on rsp_ freezes the whole pipeline; req_tready drops only while a
// result is held, and nothing is lost or repeated.
// Reset clears all valid bits and sets restitution to 1.0; the data
// registers keep their contents, so there is no clearing pass.
// ----------------------------------------------------------------------------
module collision_impulse_resolver (
   input  logic         clock,
   input  logic         reset,
   // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
   // inv_mass_a, inv_mass_b, normal_x, normal_y, normal_z, depth
   input  logic [383:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // new_vel_a_x, new_vel_a_y, new_vel_a_z, new_vel_b_x, new_vel_b_y, new_vel_b_z
   output logic [191:0] rsp_tdata,
   // outcome
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);

   localparam int LAST = cir_pkg::ST_OUT;

   cir_pkg::item_type pipe_ff [0:LAST];
   cir_pkg::item_type pipe_in [0:LAST];
   logic [LAST:0]     vld_ff;
   logic [LAST:0]     vld_in;
   logic [16:0]       rest_ff;
   logic [16:0]       rest_in;
   logic              adv;

   function automatic logic [31:0] sat39(logic [38:0] x);
      if (x[38:31] == {8{x[38]}})
         return x[31:0];
      return x[38] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   function automatic cir_pkg::item_type load_fn(logic [383:0] w);
      cir_pkg::item_type o;
      o = '0;
      for (int i = 0; i < 3; i++) begin
         o.va[i] = w[32*i +: 32];
         o.vb[i] = w[96 + 32*i +: 32];
         o.nv[i] = w[256 + 32*i +: 32];
      end
      o.ma        = w[223:192];
      o.mb        = w[255:224];
      o.neg_depth = w[383];
      o.nzero     = (w[351:256] == '0);
      return o;
   endfunction

   function automatic cir_pkg::item_type stage_fn(int s, cir_pkg::item_type d,
                                                  logic [16:0] rest);
      cir_pkg::item_type o;
      logic [35:0] cur;
      logic [35:0] trial;
      logic [33:0] wsh;
      logic [32:0] ush;
      logic [31:0] mag;
      logic [32:0] m33;
      logic [58:0] psum;
      logic [34:0] vsum;
      logic [17:0] k;
      logic [52:0] ksum;
      logic [61:0] wide;
      o = d;
      if (s == cir_pkg::ST_SQ) begin
         for (int i = 0; i < 3; i++) begin
            o.sq[i] = 64'($signed(d.nv[i])) * 64'($signed(d.nv[i]));
            o.r[i]  = 33'($signed(d.vb[i])) - 33'($signed(d.va[i]));
         end
         o.msum = 33'(d.ma) + 33'(d.mb);
      end
      if (s == cir_pkg::ST_SUM) begin
         o.rad  = d.sq[0] + d.sq[1] + d.sq[2];
         o.srem = '0;
         o.root = '0;
         // ma <= msum, so the top weight bit is set only when they are equal
         for (int j = 0; j < 2; j++) begin
            m33 = {1'b0, (j == 0) ? d.ma : d.mb};
            if (m33 >= d.msum) begin
               o.wq[j]   = 25'd1;
               o.wrem[j] = m33 - d.msum;
            end else begin
               o.wq[j]   = 25'd0;
               o.wrem[j] = m33;
            end
         end
      end
      if (s >= cir_pkg::ST_SQRT0 && s < cir_pkg::ST_SQRT0 + cir_pkg::SQRT_STEPS) begin
         cur   = {d.srem, d.rad[63:62]};
         trial = {2'b00, d.root, 2'b01};
         o.rad = {d.rad[61:0], 2'b00};
         if (cur >= trial) begin
            o.srem = 34'(cur - trial);
            o.root = {d.root[30:0], 1'b1};
         end else begin
            o.srem = cur[33:0];
            o.root = {d.root[30:0], 1'b0};
         end
      end
      if (s >= cir_pkg::ST_SQRT0 && s < cir_pkg::ST_SQRT0 + cir_pkg::UNIT_BITS) begin
         for (int j = 0; j < 2; j++) begin
            wsh = {d.wrem[j], 1'b0};
            if (wsh >= {1'b0, d.msum}) begin
               o.wrem[j] = 33'(wsh - {1'b0, d.msum});
               o.wq[j]   = {d.wq[j][23:0], 1'b1};
            end else begin
               o.wrem[j] = wsh[32:0];
               o.wq[j]   = {d.wq[j][23:0], 1'b0};
            end
         end
      end
      if (s == cir_pkg::ST_UINIT) begin
         // |n| <= len, so the integer part of the unit component is 0 or 1
         for (int i = 0; i < 3; i++) begin
            o.nneg[i] = d.nv[i][31];
            mag = d.nv[i][31] ? (32'd0 - d.nv[i]) : d.nv[i];
            if (mag >= d.root) begin
               o.uq[i]   = 25'd1;
               o.urem[i] = mag - d.root;
            end else begin
               o.uq[i]   = 25'd0;
               o.urem[i] = mag;
            end
         end
      end
      if (s >= cir_pkg::ST_UDIV0 && s < cir_pkg::ST_UDIV0 + cir_pkg::UNIT_BITS) begin
         for (int i = 0; i < 3; i++) begin
            ush = {d.urem[i], 1'b0};
            if (ush >= {1'b0, d.root}) begin
               o.urem[i] = 32'(ush - {1'b0, d.root});
               o.uq[i]   = {d.uq[i][23:0], 1'b1};
            end else begin
               o.urem[i] = ush[31:0];
               o.uq[i]   = {d.uq[i][23:0], 1'b0};
            end
         end
      end
      if (s == cir_pkg::ST_USIGN) begin
         for (int i = 0; i < 3; i++)
            o.u[i] = d.nneg[i] ? (26'd0 - {1'b0, d.uq[i]}) : {1'b0, d.uq[i]};
      end
      if (s == cir_pkg::ST_PROD) begin
         for (int i = 0; i < 3; i++)
            o.p[i] = 59'($signed(d.r[i])) * 59'($signed(d.u[i]));
      end
      if (s == cir_pkg::ST_VN) begin
         vsum = '0;
         // bias negative terms so the shift truncates toward zero
         for (int i = 0; i < 3; i++) begin
            psum = d.p[i] + 59'({24{d.p[i][58]}});
            vsum = vsum + psum[58:24];
         end
         o.vn = vsum;
         priority if (d.neg_depth)  o.outcome = cir_pkg::OUT_NO_CONTACT;
         else if (d.nzero)          o.outcome = cir_pkg::OUT_DEGENERATE;
         else if (vsum[34])         o.outcome = cir_pkg::OUT_SEPARATING;
         else if (d.msum == '0)     o.outcome = cir_pkg::OUT_DEGENERATE;
         else                       o.outcome = cir_pkg::OUT_APPLIED;
      end
      if (s == cir_pkg::ST_KVN) begin
         k = 18'(cir_pkg::REST_ONE) + 18'(rest);
         o.kvn = 53'($signed({1'b0, k})) * 53'($signed(d.vn));
      end
      if (s == cir_pkg::ST_T) begin
         ksum = d.kvn + 53'({cir_pkg::REST_BITS{d.kvn[52]}});
         o.t  = ksum[52:cir_pkg::REST_BITS];
      end
      if (s == cir_pkg::ST_SP) begin
         for (int j = 0; j < 2; j++)
            o.sp[j] = 62'($signed(d.t)) * 62'($signed({1'b0, d.wq[j]}));
      end
      if (s == cir_pkg::ST_S) begin
         for (int j = 0; j < 2; j++) begin
            wide   = d.sp[j] + 62'({24{d.sp[j][61]}});
            o.s[j] = wide[61:24];
         end
      end
      if (s == cir_pkg::ST_DP) begin
         for (int i = 0; i < 3; i++) begin
            o.dp[i]     = 62'($signed(d.s[0])) * 62'($signed(d.u[i]));
            o.dp[3 + i] = 62'($signed(d.s[1])) * 62'($signed(d.u[i]));
         end
      end
      if (s == cir_pkg::ST_ADD) begin
         for (int i = 0; i < 3; i++) begin
            wide = d.dp[i] + 62'({24{d.dp[i][61]}});
            o.sum[i] = 39'($signed(d.va[i])) + 39'($signed(wide[61:24]));
            wide = d.dp[3 + i] + 62'({24{d.dp[3 + i][61]}});
            o.sum[3 + i] = 39'($signed(d.vb[i])) - 39'($signed(wide[61:24]));
         end
      end
      if (s == cir_pkg::ST_OUT) begin
         for (int i = 0; i < 3; i++) begin
            if (d.outcome == cir_pkg::OUT_APPLIED) begin
               o.res[i]     = sat39(d.sum[i]);
               o.res[3 + i] = sat39(d.sum[3 + i]);
            end else begin
               o.res[i]     = d.va[i];
               o.res[3 + i] = d.vb[i];
            end
         end
      end
      return o;
   endfunction

   assign adv        = !vld_ff[LAST] || rsp_tready;
   assign req_tready = adv;
   assign rest_in    = csr_wr_en ? csr_wr_data : rest_ff;

   assign pipe_in[0] = load_fn(req_tdata);

   assign vld_in = {vld_ff[LAST-1:0], req_tvalid};

   for (genvar g = 1; g <= LAST; g++) begin : g_stage
      assign pipe_in[g] = stage_fn(g, pipe_ff[g-1], rest_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rest_ff <= 17'(cir_pkg::REST_ONE);
      end else begin
         rest_ff <= rest_in;
         if (adv)
            vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 0; g <= LAST; g++)
            pipe_ff[g] <= pipe_in[g];
      end
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = pipe_ff[LAST].res;
   assign rsp_tuser  = pipe_ff[LAST].outcome;

endmodule

@@ design/cir_checker.sv @@
// ----------------------------------------------------------------------------
// cir_checker
// Port-level checks of the collision impulse resolver.
// ----------------------------------------------------------------------------
module cir_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [191:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // input side blocks only while a result waits
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req ready does not follow rsp stall");

   // a rejected word must not be dropped by the sender either way; ready low
   // implies the pipeline is frozen, so the output word cannot leave
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with empty output");

endmodule

bind collision_impulse_resolver cir_checker u_cir_checker (.*);
